FILE: rtl/kfpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// kfpm_pkg: shared types and constants of the knob filter parameter mapper
// widths, parameter kinds, bank codes, register indexes and reset values
// ============================================================================
package kfpm_pkg;

    localparam int KNOB_COUNT_DEF = 44;
    localparam int KNOB_W         = 6;
    localparam int SAMPLE_W       = 8;
    localparam int TIME_W         = 16;
    localparam int TRACK_COUNT    = 16;
    localparam int TRACK_W        = 4;
    localparam int KIND_W         = 3;
    localparam int VALUE_W        = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int QUEUE_DEPTH    = 2;

    // parameter kinds
    localparam logic [KIND_W-1:0] KIND_OUT_VOL   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PITCH     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ATTACK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRACK_VOL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TEMPO     = 3'd5;

    // knob banks
    localparam logic [2:0] BANK_OUT_VOL   = 3'd0;
    localparam logic [2:0] BANK_PITCH     = 3'd1;
    localparam logic [2:0] BANK_ATTACK    = 3'd2;
    localparam logic [2:0] BANK_RELEASE   = 3'd3;
    localparam logic [2:0] BANK_TRACK_VOL = 3'd4;

    localparam logic [KNOB_W-1:0]   TEMPO_KNOB = 6'd42;
    localparam logic [SAMPLE_W-1:0] PITCH_FLIP = 8'h80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_RECIP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME      = 3'd4;

    localparam logic [7:0]  RST_VOLUME_OFFSET = 8'd71;
    localparam logic [15:0] RST_VOLUME_RECIP  = 16'd20905;
    localparam logic [7:0]  RST_JITTER_LIMIT  = 8'd2;
    localparam logic [15:0] RST_COARSE_STEP   = 16'd238;
    localparam logic [15:0] RST_MIN_TIME      = 16'd20;

    typedef struct packed {
        logic [7:0]  volume_offset;
        logic [15:0] volume_recip;
        logic [7:0]  jitter_limit;
        logic [15:0] coarse_step;
        logic [15:0] min_time;
    } kfpm_cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [KNOB_W-1:0]   knob;
        logic [SAMPLE_W-1:0] raw;
        logic                fine;
        logic                direct;
        logic                active;
        logic [KIND_W-1:0]   kind;
        logic [TRACK_W-1:0]  target;
    } kfpm_item_t;

endpackage
`default_nettype wire

FILE: rtl/kfpm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// kfpm_front: input side
// accepts knob items, drops unknown knobs and classifies kind and target
// ============================================================================
module kfpm_front
    import kfpm_pkg::*;
#(
    parameter int KNOB_COUNT = KNOB_COUNT_DEF
)
(
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [KNOB_W-1:0]   knob_index,
    input  wire logic [SAMPLE_W-1:0] raw_sample,
    input  wire logic                fine_mode,
    input  wire logic                upper_tracks,
    input  wire logic                envelope_direct,
    input  wire logic                q_full,
    output logic                     push,
    output kfpm_item_t               push_item
);

    localparam logic [KNOB_W-1:0] KNOB_LIMIT = KNOB_W'(KNOB_COUNT);

    logic [2:0]         bank;
    logic [2:0]         pos;
    logic [TRACK_W-1:0] track;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && (knob_index < KNOB_LIMIT);
    assign bank     = knob_index[5:3];
    assign pos      = knob_index[2:0];
    assign track    = {upper_tracks, pos};

    always_comb
    begin
        push_item.knob   = knob_index;
        push_item.raw    = raw_sample;
        push_item.fine   = fine_mode;
        push_item.direct = envelope_direct;
        push_item.active = 1'b1;
        push_item.kind   = KIND_OUT_VOL;
        push_item.target = {1'b0, pos};
        case (bank)
            BANK_OUT_VOL:
            begin
                push_item.kind   = KIND_OUT_VOL;
            end
            BANK_PITCH:
            begin
                push_item.kind   = KIND_PITCH;
            end
            BANK_ATTACK:
            begin
                push_item.kind   = KIND_ATTACK;
                push_item.target = track;
            end
            BANK_RELEASE:
            begin
                push_item.kind   = KIND_RELEASE;
                push_item.target = track;
            end
            BANK_TRACK_VOL:
            begin
                push_item.kind   = KIND_TRACK_VOL;
                push_item.target = track;
            end
            default:
            begin
                // general knobs: only tempo reports
                push_item.kind   = KIND_TEMPO;
                push_item.target = '0;
                push_item.active = (knob_index == TEMPO_KNOB);
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/kfpm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// kfpm_queue: short item queue between front and back
// lets the input side keep taking items while the back is busy
// ============================================================================
module kfpm_queue
    import kfpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire kfpm_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            head_vld,
    output kfpm_item_t      head_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    kfpm_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_FULL);
    assign head_vld  = (cnt_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/kfpm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// kfpm_back: execution side
// per-knob level memory read-modify-write, change test, value mapping,
// envelope time registers and the result register
// ============================================================================
module kfpm_back
    import kfpm_pkg::*;
#(
    parameter int KNOB_COUNT = KNOB_COUNT_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kfpm_cfg_t            cfg,
    input  wire logic                 head_vld,
    input  wire kfpm_item_t           head_item,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [KIND_W-1:0]         param_kind,
    output logic [TRACK_W-1:0]        target,
    output logic signed [VALUE_W-1:0] param_value,
    output logic                      apply_volume
);

    localparam int AW = $clog2(KNOB_COUNT);

    // level memory entry: {filtered, last reported}
    logic [2*SAMPLE_W-1:0] lvl_mem [KNOB_COUNT];
    logic [KNOB_COUNT-1:0] lvl_vld_reg;
    logic [2*SAMPLE_W-1:0] rd_data_reg;
    logic                  rd_hit_reg;

    logic                  a_vld_reg;
    kfpm_item_t            a_item_reg;
    logic                  b_vld_reg;
    kfpm_item_t            b_item_reg;
    logic [SAMPLE_W-1:0]   b_f_reg;
    logic [SAMPLE_W-1:0]   b_last_reg;

    logic [TIME_W-1:0]     atk_reg [TRACK_COUNT];
    logic [TIME_W-1:0]     rel_reg [TRACK_COUNT];

    logic                      out_vld_reg;
    logic [KIND_W-1:0]         kind_reg;
    logic [TRACK_W-1:0]        target_reg;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      apply_reg;

    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             a_addr;
    logic [SAMPLE_W-1:0]       cur;
    logic [SAMPLE_W-1:0]       last;
    logic signed [SAMPLE_W:0]  delta;
    logic signed [SAMPLE_W:0]  half;
    logic [SAMPLE_W:0]         nf_wide;
    logic [SAMPLE_W-1:0]       nf;
    logic [SAMPLE_W-1:0]       absdiff;
    logic                      a_is_vol;
    logic                      report;
    logic                      a_adv;
    logic                      b_adv;
    logic                      b_free;

    logic [23:0]               vol_prod;
    logic signed [9:0]         vol_int;
    logic [TIME_W-1:0]         old_t;
    logic [TIME_W-1:0]         fine_t;
    logic [TIME_W-1:0]         step_m1;
    logic [2*TIME_W-1:0]       coarse_prod;
    logic [TIME_W-1:0]         raw_t;
    logic [TIME_W-1:0]         new_t;

    assign pop     = head_vld && !a_vld_reg;
    assign rd_addr = head_item.knob[AW-1:0];
    assign a_addr  = a_item_reg.knob[AW-1:0];

    // stage a: filter and change test
    always_comb
    begin
        cur     = rd_hit_reg ? rd_data_reg[2*SAMPLE_W-1:SAMPLE_W] : '0;
        last    = rd_hit_reg ? rd_data_reg[SAMPLE_W-1:0] : '0;
        delta   = $signed({1'b0, a_item_reg.raw}) - $signed({1'b0, cur});
        half    = delta >>> 1;
        if (delta[SAMPLE_W] && delta[0])
        begin
            half = half + 9'sd1;
        end
        nf_wide = {1'b0, cur} + half;
        nf      = nf_wide[SAMPLE_W-1:0];
        absdiff = (nf >= last) ? (nf - last) : (last - nf);
        a_is_vol = a_item_reg.kind inside {KIND_OUT_VOL, KIND_TRACK_VOL};
        if (!a_item_reg.active)
        begin
            report = 1'b0;
        end
        else if (a_is_vol)
        begin
            report = (absdiff > cfg.jitter_limit);
        end
        else
        begin
            report = (nf != last);
        end
    end

    assign b_adv  = b_vld_reg && (!out_vld_reg || !out_stall);
    assign b_free = !b_vld_reg || b_adv;
    assign a_adv  = a_vld_reg && (!report || b_free);

    // stage b: value mapping
    always_comb
    begin
        vol_prod = 24'(b_f_reg) * 24'(cfg.volume_recip);
        vol_int  = $signed({2'b00, vol_prod[23:16]}) - $signed({2'b00, cfg.volume_offset});
        // truncate toward zero for negative results with a fraction
        if ((vol_prod[23:16] < cfg.volume_offset) && (vol_prod[15:0] != '0))
        begin
            vol_int = vol_int + 10'sd1;
        end
        old_t = (b_item_reg.kind == KIND_ATTACK) ? atk_reg[b_item_reg.target]
                                                 : rel_reg[b_item_reg.target];
        fine_t      = old_t + TIME_W'(b_f_reg) - TIME_W'(b_last_reg);
        step_m1     = TIME_W'(b_f_reg) - 16'd1;
        coarse_prod = step_m1 * cfg.coarse_step;
        raw_t       = b_item_reg.fine ? fine_t : coarse_prod[TIME_W-1:0];
        new_t       = (raw_t < cfg.min_time) ? cfg.min_time : raw_t;
        case (b_item_reg.kind)
            KIND_OUT_VOL, KIND_TRACK_VOL:
            begin
                value_next = VALUE_W'(vol_int);
            end
            KIND_PITCH:
            begin
                value_next = $signed({9'b0, b_f_reg ^ PITCH_FLIP});
            end
            KIND_ATTACK, KIND_RELEASE:
            begin
                value_next = $signed({1'b0, new_t});
            end
            default:
            begin
                value_next = $signed({9'b0, b_f_reg});
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_vld_reg <= '0;
            rd_hit_reg  <= 1'b0;
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < TRACK_COUNT; i++)
            begin
                atk_reg[i] <= '0;
                rel_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                rd_hit_reg <= lvl_vld_reg[rd_addr];
                a_vld_reg  <= 1'b1;
            end
            else if (a_adv)
            begin
                a_vld_reg  <= 1'b0;
            end
            if (a_adv)
            begin
                lvl_vld_reg[a_addr] <= 1'b1;
            end
            if (a_adv && report)
            begin
                b_vld_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_vld_reg <= 1'b0;
            end
            if (b_adv)
            begin
                out_vld_reg <= 1'b1;
                if (b_item_reg.kind == KIND_ATTACK)
                begin
                    atk_reg[b_item_reg.target] <= new_t;
                end
                if (b_item_reg.kind == KIND_RELEASE)
                begin
                    rel_reg[b_item_reg.target] <= new_t;
                end
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= lvl_mem[rd_addr];
            a_item_reg  <= head_item;
        end
        if (a_adv)
        begin
            lvl_mem[a_addr] <= {nf, report ? nf : last};
        end
        if (a_adv && report)
        begin
            b_item_reg <= a_item_reg;
            b_f_reg    <= nf;
            b_last_reg <= last;
        end
        if (b_adv)
        begin
            kind_reg   <= b_item_reg.kind;
            target_reg <= b_item_reg.target;
            value_reg  <= value_next;
            apply_reg  <= (b_item_reg.kind == KIND_TRACK_VOL) && b_item_reg.direct;
        end
    end

    assign out_valid    = out_vld_reg;
    assign param_kind   = kind_reg;
    assign target       = target_reg;
    assign param_value  = value_reg;
    assign apply_volume = apply_reg;

`ifndef NO_ASSERTIONS
    a_attack_written: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && b_item_reg.kind == KIND_ATTACK)
        |=> (value_reg[TIME_W-1:0] == atk_reg[target_reg]))
        else $error("attack result differs from stored time");

    a_release_written: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && b_item_reg.kind == KIND_RELEASE)
        |=> (value_reg[TIME_W-1:0] == rel_reg[target_reg]))
        else $error("release result differs from stored time");

    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (kind_reg == KIND_OUT_VOL || kind_reg == KIND_TRACK_VOL))
        |-> (value_reg <= 17'sd255 && value_reg >= -17'sd255))
        else $error("volume result out of range");

    a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        (a_vld_reg && $past(a_vld_reg) && !$past(a_adv))
        |-> $stable(rd_data_reg))
        else $error("level read data changed while item waits");
`endif

endmodule
`default_nettype wire

FILE: rtl/knob_filter_param_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// knob_filter_param_mapper_unit: knob smoothing and parameter mapping
// filters each knob sample, tests for a reportable change and maps it to
// volume, pitch, envelope time or tempo results
// ============================================================================
// items pass the queue, stage a (level read, filter, change test), stage b
// (value mapping) and the result register; the back takes no new item until the
//   last has left stage a (level memory read, then written back before the next read)
// the input queue takes items every cycle until it holds 2
// reset: registers to defaults, level valid bits and envelope times cleared
//   at once; no clearing pass, items accepted right after reset
module knob_filter_param_mapper_unit
    import kfpm_pkg::*;
#(
    parameter int KNOB_COUNT = KNOB_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [KNOB_W-1:0]     knob_index,
    input  wire logic [SAMPLE_W-1:0]   raw_sample,
    input  wire logic                  fine_mode,
    input  wire logic                  upper_tracks,
    input  wire logic                  envelope_direct,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [KIND_W-1:0]          param_kind,
    output logic [TRACK_W-1:0]         target,
    output logic signed [VALUE_W-1:0]  param_value,
    output logic                       apply_volume
);

    kfpm_cfg_t  cfg_reg;
    logic       q_full;
    logic       push;
    kfpm_item_t push_item;
    logic       pop;
    logic       head_vld;
    kfpm_item_t head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_offset <= RST_VOLUME_OFFSET;
            cfg_reg.volume_recip  <= RST_VOLUME_RECIP;
            cfg_reg.jitter_limit  <= RST_JITTER_LIMIT;
            cfg_reg.coarse_step   <= RST_COARSE_STEP;
            cfg_reg.min_time      <= RST_MIN_TIME;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VOLUME_OFFSET: cfg_reg.volume_offset <= cfg_data[7:0];
                CFG_VOLUME_RECIP:  cfg_reg.volume_recip  <= cfg_data;
                CFG_JITTER_LIMIT:  cfg_reg.jitter_limit  <= cfg_data[7:0];
                CFG_COARSE_STEP:   cfg_reg.coarse_step   <= cfg_data;
                CFG_MIN_TIME:      cfg_reg.min_time      <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    kfpm_front #(
        .KNOB_COUNT (KNOB_COUNT)
    ) u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .knob_index      (knob_index),
        .raw_sample      (raw_sample),
        .fine_mode       (fine_mode),
        .upper_tracks    (upper_tracks),
        .envelope_direct (envelope_direct),
        .q_full          (q_full),
        .push            (push),
        .push_item       (push_item)
    );

    kfpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head_vld  (head_vld),
        .head_item (head_item)
    );

    kfpm_back #(
        .KNOB_COUNT (KNOB_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_vld     (head_vld),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .param_kind   (param_kind),
        .target       (target),
        .param_value  (param_value),
        .apply_volume (apply_volume)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of knob_filter_param_mapper_unit
// sends knob samples through the valid/stall input and keeps its own copy of
// the per-knob smoothing, change detection and parameter mapping; every
// reported parameter is checked in order, field by field, under random
// idling, long output hold-offs and several register settings
// ============================================================================
module tb_top;
    import kfpm_pkg::*;

    typedef struct {
        logic [KNOB_W-1:0]   knob;
        logic [SAMPLE_W-1:0] raw;
        logic                fine;
        logic                upper;
        logic                direct;
    } knob_sample_t;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [TRACK_W-1:0] target;
        logic [VALUE_W-1:0] value;
        logic               apply;
    } param_update_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int GENERAL_KNOB0  = 40;

    // register indexes past the end of the list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [KNOB_W-1:0]          knob_index = '0;
    logic [SAMPLE_W-1:0]        raw_sample = '0;
    logic                       fine_mode = 1'b0;
    logic                       upper_tracks = 1'b0;
    logic                       envelope_direct = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [KIND_W-1:0]          param_kind;
    logic [TRACK_W-1:0]         target;
    logic signed [VALUE_W-1:0]  param_value;
    logic                       apply_volume;

    kfpm_cfg_t mapper_cfg = '{RST_VOLUME_OFFSET, RST_VOLUME_RECIP, RST_JITTER_LIMIT,
                              RST_COARSE_STEP, RST_MIN_TIME};
    logic [SAMPLE_W-1:0] smoothed_level [KNOB_COUNT_DEF] = '{default: '0};
    logic [SAMPLE_W-1:0] last_reported [KNOB_COUNT_DEF]  = '{default: '0};
    logic [TIME_W-1:0]   attack_times [TRACK_COUNT]      = '{default: '0};
    logic [TIME_W-1:0]   release_times [TRACK_COUNT]     = '{default: '0};

    knob_sample_t  samples_to_send[$];
    knob_sample_t  sample_on_bus;
    param_update_t expected_updates[$];
    param_update_t update_due;

    int samples_accepted = 0;
    int updates_seen = 0;
    int mismatches = 0;
    int settings_applied = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int holds_done = 0;
    int hold_marks[3] = '{100, 600, 900};
    int quiet_cycles = 0;

    knob_filter_param_mapper_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .knob_index      (knob_index),
        .raw_sample      (raw_sample),
        .fine_mode       (fine_mode),
        .upper_tracks    (upper_tracks),
        .envelope_direct (envelope_direct),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .param_kind      (param_kind),
        .target          (target),
        .param_value     (param_value),
        .apply_volume    (apply_volume)
    );

    always #1 clk = ~clk;

    function automatic logic [VALUE_W-1:0] scaled_volume(input logic [SAMPLE_W-1:0] level);
        longint num;
        longint q;
        num = longint'(level) * longint'(mapper_cfg.volume_recip)
            - (longint'(mapper_cfg.volume_offset) << 16);
        q = (num >= 0) ? num / 65536 : -((-num) / 65536);
        return q[VALUE_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] stepped_time(input logic [TIME_W-1:0] old_time,
                                                       input logic [SAMPLE_W-1:0] level,
                                                       input logic [SAMPLE_W-1:0] prev,
                                                       input logic fine);
        logic [TIME_W-1:0] t;
        if (fine)
            t = old_time + {8'd0, level} - {8'd0, prev};
        else
            t = ({8'd0, level} - 16'd1) * mapper_cfg.coarse_step;
        if (t < mapper_cfg.min_time)
            t = mapper_cfg.min_time;
        return t;
    endfunction

    // smooth the sample, decide on a report and queue the expected update
    task automatic map_knob_sample(input knob_sample_t s);
        int                  cur;
        int                  nf;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] prev;
        logic [SAMPLE_W-1:0] diff;
        logic [2:0]          bank;
        logic [TRACK_W-1:0]  trk;
        param_update_t       r;
        bit                  fires;
        if (s.knob >= KNOB_COUNT_DEF)
            return;
        cur = smoothed_level[s.knob];
        nf = cur + (int'(s.raw) - cur) / 2;
        level = nf[SAMPLE_W-1:0];
        smoothed_level[s.knob] = level;
        prev = last_reported[s.knob];
        diff = (level > prev) ? level - prev : prev - level;
        bank = s.knob[5:3];
        trk = {s.upper, s.knob[2:0]};
        fires = 1'b0;
        r = '{default: '0};
        if (s.knob < GENERAL_KNOB0)
        begin
            case (bank)
                BANK_OUT_VOL, BANK_TRACK_VOL:
                    if (diff > mapper_cfg.jitter_limit)
                    begin
                        fires = 1'b1;
                        r.value = scaled_volume(level);
                        if (bank == BANK_OUT_VOL)
                        begin
                            r.kind = KIND_OUT_VOL;
                            r.target = {1'b0, s.knob[2:0]};
                        end
                        else
                        begin
                            r.kind = KIND_TRACK_VOL;
                            r.target = trk;
                            r.apply = s.direct;
                        end
                    end
                BANK_PITCH:
                    if (level != prev)
                    begin
                        fires = 1'b1;
                        r.kind = KIND_PITCH;
                        r.target = {1'b0, s.knob[2:0]};
                        r.value = VALUE_W'(level ^ PITCH_FLIP);
                    end
                BANK_ATTACK:
                    if (level != prev)
                    begin
                        fires = 1'b1;
                        attack_times[trk] = stepped_time(attack_times[trk], level, prev, s.fine);
                        r.kind = KIND_ATTACK;
                        r.target = trk;
                        r.value = VALUE_W'(attack_times[trk]);
                    end
                default:
                    if (level != prev)
                    begin
                        fires = 1'b1;
                        release_times[trk] = stepped_time(release_times[trk], level, prev,
                                                          s.fine);
                        r.kind = KIND_RELEASE;
                        r.target = trk;
                        r.value = VALUE_W'(release_times[trk]);
                    end
            endcase
        end
        else if (s.knob == TEMPO_KNOB && level != prev)
        begin
            fires = 1'b1;
            r.kind = KIND_TEMPO;
            r.value = VALUE_W'(level);
        end
        if (fires)
        begin
            last_reported[s.knob] = level;
            expected_updates.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_VOLUME_OFFSET: mapper_cfg.volume_offset = data[7:0];
            CFG_VOLUME_RECIP:  mapper_cfg.volume_recip = data;
            CFG_JITTER_LIMIT:  mapper_cfg.jitter_limit = data[7:0];
            CFG_COARSE_STEP:   mapper_cfg.coarse_step = data;
            CFG_MIN_TIME:      mapper_cfg.min_time = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] offset,
                                  input logic [CFG_DATA_W-1:0] recip,
                                  input logic [CFG_DATA_W-1:0] jitter,
                                  input logic [CFG_DATA_W-1:0] step,
                                  input logic [CFG_DATA_W-1:0] min_t);
        write_reg(CFG_VOLUME_OFFSET, offset);
        write_reg(CFG_VOLUME_RECIP, recip);
        write_reg(CFG_JITTER_LIMIT, jitter);
        write_reg(CFG_COARSE_STEP, step);
        write_reg(CFG_MIN_TIME, min_t);
        settings_applied++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic add_sample(input int knob, input int raw, input bit fine, input bit upper,
                              input bit direct);
        knob_sample_t s;
        s.knob = KNOB_W'(knob);
        s.raw = SAMPLE_W'(raw);
        s.fine = fine;
        s.upper = upper;
        s.direct = direct;
        samples_to_send.push_back(s);
    endtask

    // bursts on one knob around one level, so that the filter settles and
    // small moves test the change thresholds; a few out-of-range knobs
    task automatic add_random_samples(input int count);
        int           made;
        int           reps;
        int           level;
        int           jitter;
        int           v;
        knob_sample_t s;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 5)
            begin
                s.knob = KNOB_W'($urandom_range(63, KNOB_COUNT_DEF));
                s.raw = SAMPLE_W'($urandom);
                s.fine = 1'($urandom);
                s.upper = 1'($urandom);
                s.direct = 1'($urandom);
                samples_to_send.push_back(s);
            end
            else
            begin
                s.knob = KNOB_W'($urandom_range(KNOB_COUNT_DEF - 1));
                s.upper = 1'($urandom);
                s.direct = 1'($urandom);
                case ($urandom_range(3))
                    0: level = 0;
                    1: level = 255;
                    default: level = int'($urandom_range(255));
                endcase
                reps = int'($urandom_range(6, 1));
                jitter = int'($urandom_range(4));
                repeat (reps)
                begin
                    v = level + int'($urandom_range(2 * jitter)) - jitter;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    s.raw = SAMPLE_W'(v);
                    s.fine = 1'($urandom);
                    samples_to_send.push_back(s);
                    made++;
                end
            end
        end
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || expected_updates.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                map_knob_sample(sample_on_bus);
                samples_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_on_bus = samples_to_send.pop_front();
                    in_valid <= 1'b1;
                    knob_index <= sample_on_bus.knob;
                    raw_sample <= sample_on_bus.raw;
                    fine_mode <= sample_on_bus.fine;
                    upper_tracks <= sample_on_bus.upper;
                    envelope_direct <= sample_on_bus.direct;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall source
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                updates_seen++;
                if (expected_updates.size() == 0)
                begin
                    report_mismatch("update with none expected, param_kind", param_kind, '0);
                end
                else
                begin
                    update_due = expected_updates.pop_front();
                    if (param_kind !== update_due.kind)
                        report_mismatch("param_kind", param_kind, update_due.kind);
                    if (target !== update_due.target)
                        report_mismatch("target", target, update_due.target);
                    if (param_value[VALUE_W-1:0] !== update_due.value)
                        report_mismatch("param_value", param_value[VALUE_W-1:0], update_due.value);
                    if (apply_volume !== update_due.apply)
                        report_mismatch("apply_volume", apply_volume, update_due.apply);
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (holds_done < 3 && samples_accepted >= hold_marks[holds_done])
            begin
                out_stall <= 1'b1;
                hold_left = int'($urandom_range(100, 60));
                holds_done++;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timeout after %0d cycles without an item moving", quiet_cycles);
                    $display("knob_filter_param_mapper_unit: mismatch");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every bank, filter rounding, thresholds, idle and ignored knobs
        set_idling(10, 52);
        add_sample(0, 255, 0, 0, 0);
        add_sample(0, 0, 0, 0, 0);
        add_sample(7, 1, 0, 1, 1);
        add_sample(8, 255, 0, 0, 0);
        add_sample(15, 2, 1, 1, 1);
        add_sample(16, 3, 0, 0, 0);
        add_sample(23, 255, 0, 1, 0);
        add_sample(23, 255, 1, 1, 0);
        add_sample(24, 255, 1, 0, 0);
        add_sample(24, 0, 1, 0, 0);
        add_sample(31, 255, 0, 1, 1);
        add_sample(26, 255, 1, 0, 0);
        add_sample(26, 0, 1, 0, 0);
        add_sample(32, 255, 0, 1, 1);
        add_sample(39, 255, 0, 0, 0);
        add_sample(32, 254, 0, 1, 1);
        add_sample(33, 4, 0, 0, 1);
        add_sample(33, 6, 0, 0, 1);
        add_sample(40, 255, 0, 0, 0);
        add_sample(41, 128, 1, 1, 1);
        add_sample(43, 255, 0, 0, 0);
        add_sample(42, 255, 0, 0, 0);
        add_sample(42, 255, 1, 1, 1);
        add_sample(42, 127, 0, 0, 0);
        add_sample(44, 255, 1, 1, 1);
        add_sample(63, 0, 0, 0, 0);
        wait_until_drained();

        write_settings(16'h00_00, 16'hFFFF, 16'h00_00, 16'hFFFF, 16'h0000);
        set_idling(10, 52);
        add_random_samples(300);
        wait_until_drained();

        write_settings(16'hFF_FF, 16'h0000, 16'hFF_FF, 16'h0000, 16'hFFFF);
        set_idling(52, 10);
        add_random_samples(150);
        wait_until_drained();

        write_reg(CFG_SPARE_FIRST, 16'($urandom));
        write_reg(CFG_SPARE_LAST, 16'($urandom));
        write_settings(16'($urandom), 16'($urandom), {8'($urandom), 8'($urandom_range(8))},
                       16'($urandom), 16'($urandom_range(4000)));
        set_idling(52, 10);
        add_random_samples(300);
        wait_until_drained();

        write_settings(RST_VOLUME_OFFSET, RST_VOLUME_RECIP, RST_JITTER_LIMIT,
                       RST_COARSE_STEP, RST_MIN_TIME);
        set_idling(0, 0);
        add_random_samples(300);
        wait_until_drained();

        write_settings(16'h00FF, 16'h0000, 16'h0001, 16'($urandom_range(600)),
                       16'($urandom_range(2000)));
        set_idling(0, 0);
        add_random_samples(200);
        wait_until_drained();

        $display("%0d knob samples sent, %0d parameter updates checked in order",
                 samples_accepted, updates_seen);
        $display("%0d register settings, three idling mixes, %0d long output hold-offs",
                 settings_applied, holds_done);
        if (mismatches == 0)
            $display("knob_filter_param_mapper_unit: match");
        else
            $display("knob_filter_param_mapper_unit: mismatch");
        $finish;
    end

endmodule
